@@ rtl/core/cst_pkg.sv @@
// Shared types and constants for the character stream tokenizer.
`timescale 1ns / 1ps

package cst_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 4;
   localparam int LINE_W = 20;
   localparam int COL_W  = 16;

   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
   localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(1);
   localparam logic [COL_W-1:0]  COL_RESET  = COL_W'(1);
   // column after a newline is always 1, independent of the configured start
   localparam logic [COL_W-1:0]  COL_NEWLINE = COL_W'(1);

   // token kinds
   localparam logic [KIND_W-1:0] K_SPACE     = 4'd0;
   localparam logic [KIND_W-1:0] K_IDENT     = 4'd1;
   localparam logic [KIND_W-1:0] K_STRING    = 4'd2;
   localparam logic [KIND_W-1:0] K_INT       = 4'd3;
   localparam logic [KIND_W-1:0] K_FLOAT     = 4'd4;
   localparam logic [KIND_W-1:0] K_DOT       = 4'd5;
   localparam logic [KIND_W-1:0] K_COMMA     = 4'd6;
   localparam logic [KIND_W-1:0] K_PLUS      = 4'd7;
   localparam logic [KIND_W-1:0] K_MINUS     = 4'd8;
   localparam logic [KIND_W-1:0] K_LESS      = 4'd9;
   localparam logic [KIND_W-1:0] K_GREATER   = 4'd10;
   localparam logic [KIND_W-1:0] K_EQUAL     = 4'd11;
   localparam logic [KIND_W-1:0] K_SLASH     = 4'd12;
   localparam logic [KIND_W-1:0] K_BACKSLASH = 4'd13;
   localparam logic [KIND_W-1:0] K_STAR      = 4'd14;
   localparam logic [KIND_W-1:0] K_COMMENT   = 4'd15;

   // source bytes of interest
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LESS   = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // configuration register indexes
   localparam logic CSR_FIRST_LINE   = 1'b0;
   localparam logic CSR_FIRST_COLUMN = 1'b1;

   typedef struct packed {
      logic              token_done;
      logic              token_kept;
      logic [KIND_W-1:0] token_kind;
      logic [LINE_W-1:0] token_line;
      logic [COL_W-1:0]  token_column;
      logic              char_valid;
      logic [CHAR_W-1:0] char_out;
   } result_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } scan_state_type;

endpackage

@@ rtl/core/cst_step.sv @@
// Per-byte tokenizer decision: result and next scan state from byte and state.
`timescale 1ns / 1ps

module cst_step (
   input  logic [cst_pkg::CHAR_W-1:0] in_char,
   input  cst_pkg::scan_state_type    cur,
   output cst_pkg::scan_state_type    nxt,
   output cst_pkg::result_type        result
);
   import cst_pkg::*;

   logic              close_en;
   logic              append_en;
   logic [CHAR_W-1:0] append_char;
   logic              newline;
   logic [KIND_W-1:0] kind_nx;
   logic              is_digit;
   logic              is_lower;

   assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
   assign is_lower = (in_char >= CH_LOW_A) && (in_char <= CH_LOW_Z);

   always_comb begin
      close_en    = 1'b0;
      append_en   = 1'b0;
      append_char = in_char;
      newline     = 1'b0;
      kind_nx     = cur.kind;
      if (cur.kind == K_COMMENT) begin
         if (in_char == CH_NL) begin
            close_en = 1'b1;
            newline  = 1'b1;
            kind_nx  = K_SPACE;
         end else begin
            append_en = 1'b1;
         end
      end else if (cur.kind == K_STRING) begin
         if (in_char == CH_QUOTE) begin
            close_en = 1'b1;
            kind_nx  = K_SPACE;
         end else begin
            append_en = 1'b1;
         end
      end else if (is_digit) begin
         if (cur.kind == K_SPACE) kind_nx = K_INT;
         append_en = 1'b1;
      end else begin
         unique case (in_char) inside
            CH_QUOTE: begin
               close_en = 1'b1;
               kind_nx  = K_STRING;
            end
            CH_DOT: begin
               if (cur.kind == K_INT) begin
                  kind_nx   = K_FLOAT;
                  append_en = 1'b1;
               end else begin
                  kind_nx = K_DOT;
               end
            end
            CH_COMMA:   kind_nx = K_COMMA;
            CH_PLUS:    kind_nx = K_PLUS;
            CH_MINUS:   kind_nx = K_MINUS;
            CH_LESS:    kind_nx = K_LESS;
            CH_GREATER: kind_nx = K_GREATER;
            CH_EQUAL:   kind_nx = K_EQUAL;
            CH_SPACE, CH_TAB, CH_CR: begin
               close_en = 1'b1;
               kind_nx  = K_SPACE;
            end
            CH_NL: begin
               close_en = 1'b1;
               newline  = 1'b1;
               kind_nx  = K_SPACE;
            end
            CH_SLASH: begin
               if (cur.kind == K_SPACE) kind_nx = K_SLASH;
               else if (cur.kind == K_SLASH) kind_nx = K_COMMENT;
            end
            default: begin
               if (cur.kind == K_SPACE || cur.kind == K_INT) kind_nx = K_IDENT;
               append_en = 1'b1;
               if (is_lower) append_char = in_char - CASE_OFFSET;
            end
         endcase
      end
   end

   always_comb begin
      result = '0;
      if (close_en) begin
         result.token_done   = 1'b1;
         result.token_kept   = (cur.kind != K_SPACE) && (cur.kind != K_COMMENT);
         result.token_kind   = cur.kind;
         result.token_line   = cur.line;
         result.token_column = cur.column;
      end
      if (append_en) begin
         result.char_valid = 1'b1;
         result.char_out   = append_char;
      end
   end

   // counters saturate at all ones
   always_comb begin
      nxt.kind   = kind_nx;
      nxt.line   = cur.line;
      nxt.column = cur.column;
      if (newline) begin
         if (cur.line != LINE_MAX) nxt.line = cur.line + LINE_W'(1);
         nxt.column = COL_NEWLINE;
      end else if (cur.column != COL_MAX) begin
         nxt.column = cur.column + COL_W'(1);
      end
   end

endmodule

@@ rtl/core/char_stream_tokenizer_unit.sv @@
// Top level of the character stream tokenizer: handshake, state and result registers.
// Requests go via the input register and cst_step to the result register (rsp_valid).
// Throughput: one request per cycle unless rsp_ready stalls the result channel; the
//   kind/line/column state steps per byte in cst_step, so bytes stream back to back.
// Reset (synchronous, active high): kind clears to space, line and column load 1,
//   both pipeline stages empty. Payload registers are not reset.
`timescale 1ns / 1ps

module char_stream_tokenizer_unit (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cst_pkg::CHAR_W-1:0]  req_in_char,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_token_done,
   output logic                        rsp_token_kept,
   output logic [cst_pkg::KIND_W-1:0]  rsp_token_kind,
   output logic [cst_pkg::LINE_W-1:0]  rsp_token_line,
   output logic [cst_pkg::COL_W-1:0]   rsp_token_column,
   output logic                        rsp_char_valid,
   output logic [cst_pkg::CHAR_W-1:0]  rsp_char_out,
   // configuration writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [cst_pkg::LINE_W-1:0]  csr_data
);
   import cst_pkg::*;

   // input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;

   // scan state
   scan_state_type    state_ff;
   scan_state_type    state_in;
   scan_state_type    state_step;

   // result stage
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_data_ff;
   result_type        step_result;

   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              csr_take;

   // result register is empty or drains this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // byte in the input stage is processed and moves to the result register
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   cst_step u_step (
      .in_char (in_char_ff),
      .cur     (state_ff),
      .nxt     (state_step),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) in_valid_in = 1'b1;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (advance) out_valid_in = 1'b1;
   end

   // a write loads the counter at once; user must write only while idle (unchecked)
   always_comb begin
      state_in = state_ff;
      if (advance) state_in = state_step;
      if (csr_take) begin
         unique case (csr_index)
            CSR_FIRST_LINE:   state_in.line   = csr_data;
            CSR_FIRST_COLUMN: state_in.column = csr_data[COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff.kind   <= K_SPACE;
         state_ff.line   <= LINE_RESET;
         state_ff.column <= COL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_char_ff <= req_in_char;
      if (advance) out_data_ff <= step_result;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_token_done   = out_data_ff.token_done;
   assign rsp_token_kept   = out_data_ff.token_kept;
   assign rsp_token_kind   = out_data_ff.token_kind;
   assign rsp_token_line   = out_data_ff.token_line;
   assign rsp_token_column = out_data_ff.token_column;
   assign rsp_char_valid   = out_data_ff.char_valid;
   assign rsp_char_out     = out_data_ff.char_out;

endmodule

@@ rtl/core/cst_checker.sv @@
// Port-level checks for the character stream tokenizer, bound to the top level.
`timescale 1ns / 1ps

module cst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_token_done,
   input logic                        rsp_token_kept,
   input logic [cst_pkg::KIND_W-1:0]  rsp_token_kind,
   input logic [cst_pkg::LINE_W-1:0]  rsp_token_line,
   input logic [cst_pkg::COL_W-1:0]   rsp_token_column,
   input logic                        rsp_char_valid,
   input logic [cst_pkg::CHAR_W-1:0]  rsp_char_out
);
   import cst_pkg::*;

   // kept follows from the closed kind
   a_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_kept ==
         (rsp_token_done && rsp_token_kind != K_SPACE && rsp_token_kind != K_COMMENT)))
      else $error("token_kept disagrees with token kind");

   // no close fields without a close
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_token_done) |->
         (rsp_token_kind == '0 && rsp_token_line == '0 && rsp_token_column == '0))
      else $error("token fields nonzero without token_done");

   // a byte never both closes and appends, and char_out is zero without an append
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_token_done && rsp_char_valid) &&
         (rsp_char_valid || rsp_char_out == '0))
      else $error("close and append together, or stray char_out");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_char_out) && $stable(rsp_token_line)))
      else $error("result changed while stalled");

endmodule

bind char_stream_tokenizer_unit cst_checker u_cst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_done   (rsp_token_done),
   .rsp_token_kept   (rsp_token_kept),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_line   (rsp_token_line),
   .rsp_token_column (rsp_token_column),
   .rsp_char_valid   (rsp_char_valid),
   .rsp_char_out     (rsp_char_out)
);
